### design/itra_pkg.sv
// ----------------------------------------------------------------------------
// itra_pkg
// Shared types, constants and helpers for the integer to radix ASCII core.
// ----------------------------------------------------------------------------
`default_nettype none

package itra_pkg;

  // Default value width
  localparam int DEF_VALUE_WIDTH = 64;

  // Input field width, fixed
  localparam int NUMBER_W = 64;

  // Digit value (0..35) and radix register width
  localparam int DIGIT_W = 6;

  // Configuration port widths
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 6;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_RADIX  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SIGNED = 1'd1;

  // Register reset values
  localparam logic [DIGIT_W-1:0] RADIX_RESET  = 6'd10;
  localparam logic               SIGNED_RESET = 1'b1;

  // Legal radix range
  localparam logic [DIGIT_W-1:0] RADIX_MIN = 6'd2;
  localparam logic [DIGIT_W-1:0] RADIX_MAX = 6'd36;

  // ASCII pieces
  localparam int                 CHAR_W          = 7;
  localparam logic [CHAR_W-1:0]  ASCII_ZERO      = 7'h30;
  localparam logic [CHAR_W-1:0]  ASCII_ALPHA_OFS = 7'h37;
  localparam logic [DIGIT_W-1:0] DEC_DIGITS      = 6'd10;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_SHOW
  } itra_state_t;

  // Handshake between sequencer and divider
  typedef struct packed {
    logic start;
  } itra_div_ctl_t;

  typedef struct packed {
    logic done;
  } itra_div_sts_t;

  // Map a digit value to its ASCII character
  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] dx;
    dx = {1'b0, d};
    if (d < DEC_DIGITS) begin
      return ASCII_ZERO + dx;
    end
    return ASCII_ALPHA_OFS + dx;
  endfunction

endpackage

`default_nettype wire

### design/integer_to_radix_ascii_core.sv
// ----------------------------------------------------------------------------
// integer_to_radix_ascii_core
// Converts one integer to ASCII digits in a base from 2 to 36.
// ----------------------------------------------------------------------------
// Each accepted item is converted by repeated division by the radix in one
// shared shift-subtract divider that produces one quotient bit per cycle.
// Remainders land in a digit buffer and are replayed most significant first:
// each digit is read from the buffer, then held on the output until the
// consumer takes it. in_ready is high only while the core is idle, so a new
// item is accepted only after the last digit of the previous one. The sign
// travels as out_is_negative on every digit, and out_last_digit marks the
// final digit. Radix values outside 2..36 are clamped; configuration writes
// are always taken and should be made while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_to_radix_ascii_core
  import itra_pkg::*;
#(
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // Input channel
  input  wire logic                   in_valid,
  output      logic                   in_ready,
  input  wire logic [NUMBER_W-1:0]    in_number_bits,
  // Result channel
  output      logic                   out_valid,
  input  wire logic                   out_ready,
  output      logic [CHAR_W-1:0]      out_digit_char,
  output      logic                   out_is_negative,
  output      logic                   out_last_digit,
  // Configuration channel
  input  wire logic                   cfg_valid,
  output      logic                   cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int AW = $clog2(VALUE_WIDTH);
  localparam int CW = $clog2(VALUE_WIDTH + 1);

  itra_state_t state_r, state_nxt;

  logic [DIGIT_W-1:0]     radix_r;
  logic                   signed_r;
  logic [DIGIT_W-1:0]     base_r;
  logic                   neg_r;
  logic [CW-1:0]          cnt_r;
  logic [AW-1:0]          rd_idx_r;

  logic [VALUE_WIDTH-1:0] in_val;
  logic                   in_neg;
  logic [VALUE_WIDTH-1:0] in_mag;
  logic [DIGIT_W-1:0]     in_base;

  itra_div_ctl_t          div_ctl;
  itra_div_sts_t          div_sts;
  logic [VALUE_WIDTH-1:0] div_dividend;
  logic [VALUE_WIDTH-1:0] div_quot;
  logic [DIGIT_W-1:0]     div_rem;

  logic                   mem_wr;
  logic                   mem_rd;
  logic [DIGIT_W-1:0]     mem_rd_data;
  logic                   conv_end;
  logic                   out_fire;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r  <= RADIX_RESET;
      signed_r <= SIGNED_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_RADIX:  radix_r  <= cfg_wdata;
        REG_SIGNED: signed_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Clamp radix, take the magnitude of the input
  always_comb begin
    in_val = in_number_bits[VALUE_WIDTH-1:0];
    in_neg = signed_r & in_val[VALUE_WIDTH-1];
    in_mag = in_neg ? (~in_val + 1'b1) : in_val;
    if (radix_r < RADIX_MIN) begin
      in_base = RADIX_MIN;
    end else if (radix_r > RADIX_MAX) begin
      in_base = RADIX_MAX;
    end else begin
      in_base = radix_r;
    end
  end

  // Shared divider
  assign div_dividend = (state_r == ST_IDLE) ? in_mag : div_quot;

  itra_divider #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (div_ctl),
    .dividend  (div_dividend),
    .divisor   ((state_r == ST_IDLE) ? in_base : base_r),
    .sts       (div_sts),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  // Digit buffer
  itra_digit_store #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_wr),
    .wr_addr (cnt_r[AW-1:0]),
    .wr_data (div_rem),
    .rd_en   (mem_rd),
    .rd_addr (rd_idx_r),
    .rd_data (mem_rd_data)
  );

  assign conv_end = (div_quot == '0) || (cnt_r == CW'(VALUE_WIDTH - 1));
  assign out_fire = out_valid & out_ready;

  // Sequencer: next state and strobes
  always_comb begin
    state_nxt     = state_r;
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    div_ctl.start = 1'b0;
    mem_wr        = 1'b0;
    mem_rd        = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          div_ctl.start = 1'b1;
          state_nxt     = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_sts.done) begin
          mem_wr = 1'b1;
          if (conv_end) begin
            state_nxt = ST_READ;
          end else begin
            div_ctl.start = 1'b1;
          end
        end
      end
      ST_READ: begin
        mem_rd    = 1'b1;
        state_nxt = ST_SHOW;
      end
      ST_SHOW: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = out_last_digit ? ST_IDLE : ST_READ;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Hold item attributes, advance the digit counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      rd_idx_r <= '0;
    end else begin
      if (state_r == ST_IDLE && in_valid) begin
        cnt_r <= '0;
      end else if (mem_wr) begin
        cnt_r <= cnt_r + 1'b1;
        if (conv_end) begin
          rd_idx_r <= cnt_r[AW-1:0];
        end
      end else if (out_fire && !out_last_digit) begin
        rd_idx_r <= rd_idx_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      neg_r  <= in_neg;
      base_r <= in_base;
    end
  end

  // Result fields
  assign out_digit_char  = digit_to_ascii(mem_rd_data);
  assign out_is_negative = neg_r;
  assign out_last_digit  = (rd_idx_r == '0);

endmodule

`default_nettype wire

### design/itra_divider.sv
// ----------------------------------------------------------------------------
// itra_divider
// Restoring shift-subtract divider, one quotient bit per cycle, small divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module itra_divider
  import itra_pkg::*;
#(
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire itra_div_ctl_t          ctl,
  input  wire logic [VALUE_WIDTH-1:0] dividend,
  input  wire logic [DIGIT_W-1:0]     divisor,
  output      itra_div_sts_t          sts,
  output      logic [VALUE_WIDTH-1:0] quotient,
  output      logic [DIGIT_W-1:0]     remainder
);

  localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

  logic [VALUE_WIDTH-1:0] dvd_r, dvd_nxt;
  logic [DIGIT_W-1:0]     rem_r, rem_nxt;
  logic [DIGIT_W-1:0]     dsr_r;
  logic [CNT_W-1:0]       cnt_r;
  logic                   busy_r;
  logic                   done_r;
  logic [DIGIT_W:0]       rem_sh;
  logic [DIGIT_W:0]       rem_diff;
  logic                   q_bit;

  // One restoring step
  always_comb begin
    rem_sh   = {rem_r, dvd_r[VALUE_WIDTH-1]};
    rem_diff = rem_sh - {1'b0, dsr_r};
    q_bit    = (rem_sh >= {1'b0, dsr_r});
    rem_nxt  = q_bit ? rem_diff[DIGIT_W-1:0] : rem_sh[DIGIT_W-1:0];
    dvd_nxt  = {dvd_r[VALUE_WIDTH-2:0], q_bit};
  end

  // Control: load on start, count down the steps
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (ctl.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CNT_W'(VALUE_WIDTH);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  // Datapath: dividend shifts out, quotient bits shift in
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      dvd_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign sts.done  = done_r;
  assign quotient  = dvd_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

### design/itra_digit_store.sv
// ----------------------------------------------------------------------------
// itra_digit_store
// Digit buffer: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module itra_digit_store
  import itra_pkg::*;
#(
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input  wire logic                           clk,
  input  wire logic                           wr_en,
  input  wire logic [$clog2(VALUE_WIDTH)-1:0] wr_addr,
  input  wire logic [DIGIT_W-1:0]             wr_data,
  input  wire logic                           rd_en,
  input  wire logic [$clog2(VALUE_WIDTH)-1:0] rd_addr,
  output      logic [DIGIT_W-1:0]             rd_data
);

  logic [DIGIT_W-1:0] mem [VALUE_WIDTH];
  logic [DIGIT_W-1:0] rd_data_r;

  // Write a digit
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read a digit into the output register
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire
